/* hw/rtl/shac_pkg.sv */
// Shared types and constants of the segment heap allocator.
package shac_pkg;

  localparam int AW          = 16;
  localparam int LW          = AW + 1;
  localparam int ALIGN_BYTES = 8;
  localparam int ALIGN_LOG   = $clog2(ALIGN_BYTES);

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_ZERO     = 3'd1;
  localparam logic [2:0] STAT_NOFIT    = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_HEAP   = 1'b1;

  typedef struct packed {
    logic          op;
    logic [LW-1:0] req_size;
    logic [AW-1:0] block_addr;
  } shac_in_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [AW-1:0] grant_addr;
    logic [LW-1:0] free_bytes;
  } shac_out_t;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [LW-1:0] len;
  } shac_seg_t;

  typedef enum logic [2:0] {
    COP_HOLD,
    COP_ROT,
    COP_WR,
    COP_INS,
    COP_DEL,
    COP_DELW
  } shac_cop_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_IDLE,
    ST_SCAN1,
    ST_SCAN2,
    ST_APPLY,
    ST_DONE
  } shac_state_t;

endpackage

/* hw/rtl/segment_heap_allocator_unit.sv */
// Segment heap allocator: free and used segment tables as rotating cell rings.
// One request is taken at a time: the unit stalls new requests until the result
// of the last one is handed to the output, and a result stall holds it in its done
// state. Reset and a heap_bytes write load one free segment; policy resets to first
// fit, heap to 65536.
module segment_heap_allocator_unit #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  shac_pkg::shac_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output shac_pkg::shac_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = shac_pkg::AW;
  localparam int LW = shac_pkg::LW;
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
  localparam logic [IW-1:0] K_LAST  = IW'(MAX_SEGMENTS - 1);

  shac_pkg::shac_state_t state_r, state_nxt;

  logic [1:0]    policy_r;
  logic [LW-1:0] heap_r;
  logic [CW-1:0] fcnt_r, ucnt_r;
  logic [LW-1:0] ftotal_r;

  logic          op_r;
  logic [LW:0]   need_r;
  logic [AW-1:0] addr_r;
  logic [IW-1:0] k_r;
  logic          found_r;
  logic [IW-1:0] pick_r;
  shac_pkg::shac_seg_t pick_seg_r;
  logic [LW-1:0] ulen_r;
  logic [IW-1:0] u_r;
  logic [CW-1:0] pos_r;
  logic [LW:0]   prev_end_r;
  logic [LW-1:0] prev_len_r;
  logic          has_next_r;
  shac_pkg::shac_seg_t next_seg_r;
  logic [2:0]    status_r;
  logic [AW-1:0] grant_r;

  logic          out_valid_r;
  shac_pkg::shac_out_t out_r;

  shac_pkg::shac_seg_t f_head, u_head;
  shac_pkg::shac_cop_t f_cop, u_cop;
  logic [IW-1:0]       f_pos, u_pos;
  shac_pkg::shac_seg_t f_wdata, u_wdata;

  logic          accept;
  logic          cfg_wr;
  logic          heap_wr;
  logic          scan_end;
  logic [LW:0]   need_in;
  logic [LW:0]   rnd;
  logic          early_zero, early_nofit;
  logic          k_in_f, k_in_u;
  logic          fit_hit, take;
  logic          mp, mn, free_full;
  logic          done_go;
  logic [LW-1:0] load_sz;
  logic [LW+1:0] merged;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign heap_wr   = cfg_wr && (paddr[2] == shac_pkg::REG_HEAP);
  // hold a request while busy and while the heap is reloaded
  assign in_stall  = (state_r != shac_pkg::ST_IDLE) || heap_wr;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign prdata    = (paddr[2] == shac_pkg::REG_HEAP) ? 32'(heap_r) : 32'(policy_r);
  assign scan_end  = (k_r == K_LAST);
  assign done_go   = !out_valid_r || !out_stall;

  // clamp heap size to the address space
  assign load_sz = (heap_r > LW'(1 << AW)) ? LW'(1 << AW) : heap_r;

  assign rnd         = {1'b0, in_data.req_size} + (LW + 1)'(shac_pkg::ALIGN_BYTES - 1);
  assign need_in     = (rnd >> shac_pkg::ALIGN_LOG) << shac_pkg::ALIGN_LOG;
  assign early_zero  = (in_data.req_size == '0);
  assign early_nofit = (need_in > {1'b0, ftotal_r}) || (fcnt_r == '0);

  assign k_in_f  = (CW'(k_r) < fcnt_r);
  assign k_in_u  = (CW'(k_r) < ucnt_r);
  assign fit_hit = k_in_f && ({1'b0, f_head.len} >= need_r);
  assign take    = fit_hit && (!found_r
                   || (policy_r == shac_pkg::POL_BEST  && f_head.len < pick_seg_r.len)
                   || (policy_r == shac_pkg::POL_WORST && f_head.len > pick_seg_r.len));

  assign mp = (pos_r != '0) && (prev_end_r == (LW + 1)'(addr_r));
  assign mn = has_next_r && ((LW + 1)'(addr_r) + (LW + 1)'(ulen_r)
              == (LW + 1)'(next_seg_r.start));
  assign free_full = !mp && !mn && (fcnt_r >= CNT_MAX);
  assign merged = (LW + 2)'(prev_len_r) + (LW + 2)'(ulen_r) + (LW + 2)'(next_seg_r.len);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shac_pkg::ST_LOAD: state_nxt = heap_wr ? shac_pkg::ST_LOAD : shac_pkg::ST_IDLE;
      shac_pkg::ST_IDLE: begin
        if (heap_wr) state_nxt = shac_pkg::ST_LOAD;
        else if (accept) begin
          if (in_data.op == shac_pkg::OP_ALLOC && (early_zero || early_nofit))
            state_nxt = shac_pkg::ST_DONE;
          else
            state_nxt = shac_pkg::ST_SCAN1;
        end
      end
      shac_pkg::ST_SCAN1: begin
        if (scan_end) begin
          if (op_r == shac_pkg::OP_FREE) begin
            state_nxt = (found_r || (k_in_u && u_head.start == addr_r)) ?
                        shac_pkg::ST_SCAN2 : shac_pkg::ST_DONE;
          end else if (!(found_r || fit_hit) || ucnt_r >= CNT_MAX) begin
            state_nxt = shac_pkg::ST_DONE;
          end else begin
            state_nxt = shac_pkg::ST_SCAN2;
          end
        end
      end
      shac_pkg::ST_SCAN2: begin
        if (scan_end) state_nxt = shac_pkg::ST_APPLY;
      end
      shac_pkg::ST_APPLY: state_nxt = shac_pkg::ST_DONE;
      shac_pkg::ST_DONE: begin
        if (done_go) state_nxt = shac_pkg::ST_IDLE;
      end
      default: state_nxt = shac_pkg::ST_IDLE;
    endcase
  end

  // ring commands
  always_comb begin
    f_cop   = shac_pkg::COP_HOLD;
    u_cop   = shac_pkg::COP_HOLD;
    f_pos   = '0;
    u_pos   = '0;
    f_wdata = '0;
    u_wdata = '0;
    unique case (state_r)
      shac_pkg::ST_LOAD: begin
        f_cop   = shac_pkg::COP_WR;
        f_wdata = '{start: '0, len: load_sz};
      end
      shac_pkg::ST_SCAN1: begin
        if (op_r == shac_pkg::OP_ALLOC) f_cop = shac_pkg::COP_ROT;
        else u_cop = shac_pkg::COP_ROT;
      end
      shac_pkg::ST_SCAN2: begin
        if (op_r == shac_pkg::OP_ALLOC) u_cop = shac_pkg::COP_ROT;
        else f_cop = shac_pkg::COP_ROT;
      end
      shac_pkg::ST_APPLY: begin
        if (op_r == shac_pkg::OP_ALLOC) begin
          f_pos = pick_r;
          if ({1'b0, pick_seg_r.len} == need_r) begin
            f_cop = shac_pkg::COP_DEL;
          end else begin
            f_cop   = shac_pkg::COP_WR;
            f_wdata = '{start: pick_seg_r.start + AW'(need_r),
                        len:   pick_seg_r.len - LW'(need_r)};
          end
          u_cop   = shac_pkg::COP_INS;
          u_pos   = IW'(pos_r);
          u_wdata = '{start: pick_seg_r.start, len: LW'(need_r)};
        end else if (!free_full) begin
          u_cop = shac_pkg::COP_DEL;
          u_pos = u_r;
          if (mp && mn) begin
            f_cop   = shac_pkg::COP_DELW;
            f_pos   = IW'(pos_r);
            f_wdata = '{start: '0, len: LW'(merged)};
          end else if (mp) begin
            f_cop   = shac_pkg::COP_WR;
            f_pos   = IW'(pos_r - 1'b1);
            f_wdata = '{start: AW'(prev_end_r - (LW + 1)'(prev_len_r)),
                        len: prev_len_r + ulen_r};
          end else if (mn) begin
            f_cop   = shac_pkg::COP_WR;
            f_pos   = IW'(pos_r);
            f_wdata = '{start: addr_r, len: next_seg_r.len + ulen_r};
          end else begin
            f_cop   = shac_pkg::COP_INS;
            f_pos   = IW'(pos_r);
            f_wdata = '{start: addr_r, len: ulen_r};
          end
        end
      end
      default: ;
    endcase
  end

  // rebuild the merged entry's start from prev_end - prev_len
  shac_pkg::shac_seg_t f_wdata_fix;
  always_comb begin
    f_wdata_fix = f_wdata;
    if (f_cop == shac_pkg::COP_DELW)
      f_wdata_fix.start = AW'(prev_end_r - (LW + 1)'(prev_len_r));
  end

  shac_chain #(.N(MAX_SEGMENTS), .IW(IW)) u_free (
    .clk(clk), .cop(f_cop), .pos(f_pos), .wdata(f_wdata_fix), .head(f_head)
  );

  shac_chain #(.N(MAX_SEGMENTS), .IW(IW)) u_used (
    .clk(clk), .cop(u_cop), .pos(u_pos), .wdata(u_wdata), .head(u_head)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shac_pkg::ST_LOAD;
      policy_r    <= shac_pkg::POL_FIRST;
      heap_r      <= LW'(65536);
      fcnt_r      <= '0;
      ucnt_r      <= '0;
      ftotal_r    <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == shac_pkg::REG_HEAP) heap_r <= pwdata[LW-1:0];
        else policy_r <= pwdata[1:0];
      end
      if (state_r == shac_pkg::ST_SCAN1 || state_r == shac_pkg::ST_SCAN2)
        k_r <= scan_end ? '0 : k_r + 1'b1;
      else
        k_r <= '0;
      if (state_r == shac_pkg::ST_LOAD) begin
        fcnt_r   <= (load_sz != '0) ? CW'(1) : '0;
        ucnt_r   <= '0;
        ftotal_r <= load_sz;
      end else if (state_r == shac_pkg::ST_APPLY) begin
        if (op_r == shac_pkg::OP_ALLOC) begin
          ucnt_r   <= ucnt_r + 1'b1;
          ftotal_r <= ftotal_r - LW'(need_r);
          if ({1'b0, pick_seg_r.len} == need_r) fcnt_r <= fcnt_r - 1'b1;
        end else if (!free_full) begin
          ucnt_r   <= ucnt_r - 1'b1;
          ftotal_r <= ftotal_r + ulen_r;
          if (mp && mn) fcnt_r <= fcnt_r - 1'b1;
          else if (!mp && !mn) fcnt_r <= fcnt_r + 1'b1;
        end
      end
      if (state_r == shac_pkg::ST_DONE && done_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == shac_pkg::ST_IDLE && accept) begin
      op_r       <= in_data.op;
      need_r     <= need_in;
      addr_r     <= in_data.block_addr;
      found_r    <= 1'b0;
      pos_r      <= '0;
      has_next_r <= 1'b0;
      grant_r    <= '0;
      status_r   <= early_zero ? shac_pkg::STAT_ZERO : shac_pkg::STAT_NOFIT;
    end
    if (state_r == shac_pkg::ST_SCAN1) begin
      if (op_r == shac_pkg::OP_ALLOC) begin
        if (take) begin
          found_r    <= 1'b1;
          pick_r     <= k_r;
          pick_seg_r <= f_head;
        end
        if (scan_end) begin
          if (!(found_r || fit_hit)) status_r <= shac_pkg::STAT_NOFIT;
          else if (ucnt_r >= CNT_MAX) status_r <= shac_pkg::STAT_FULL;
        end
      end else begin
        if (!found_r && k_in_u && u_head.start == addr_r) begin
          found_r <= 1'b1;
          u_r     <= k_r;
          ulen_r  <= u_head.len;
        end
        if (scan_end && !(found_r || (k_in_u && u_head.start == addr_r)))
          status_r <= shac_pkg::STAT_NOTFOUND;
      end
    end
    if (state_r == shac_pkg::ST_SCAN2) begin
      if (op_r == shac_pkg::OP_ALLOC) begin
        if (k_in_u && u_head.start < pick_seg_r.start) pos_r <= pos_r + 1'b1;
      end else if (k_in_f) begin
        if (f_head.start < addr_r) begin
          pos_r      <= pos_r + 1'b1;
          prev_end_r <= (LW + 1)'(f_head.start) + (LW + 1)'(f_head.len);
          prev_len_r <= f_head.len;
        end else if (!has_next_r) begin
          has_next_r <= 1'b1;
          next_seg_r <= f_head;
        end
      end
    end
    if (state_r == shac_pkg::ST_APPLY) begin
      if (op_r == shac_pkg::OP_ALLOC) begin
        status_r <= shac_pkg::STAT_OK;
        grant_r  <= pick_seg_r.start;
      end else begin
        status_r <= free_full ? shac_pkg::STAT_FULL : shac_pkg::STAT_OK;
      end
    end
    if (state_r == shac_pkg::ST_DONE && done_go) begin
      out_r.status     <= status_r;
      out_r.grant_addr <= (status_r == shac_pkg::STAT_OK) ? grant_r : '0;
      out_r.free_bytes <= ftotal_r;
    end
  end

endmodule

/* hw/rtl/shac_cell.sv */
// One segment entry of a table row: holds, rotates, shifts or takes new data.
module shac_cell #(
  parameter int IW  = 5,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  shac_pkg::shac_cop_t cop,
  input  logic [IW-1:0]       pos,
  input  shac_pkg::shac_seg_t wdata,
  input  shac_pkg::shac_seg_t from_next,
  input  shac_pkg::shac_seg_t from_prev,
  output shac_pkg::shac_seg_t q
);

  shac_pkg::shac_seg_t seg_r;
  shac_pkg::shac_seg_t seg_nxt;
  logic [IW-1:0] me;
  logic [IW-1:0] me_p1;

  assign me    = IW'(IDX);
  assign me_p1 = IW'(IDX + 1);
  assign q     = seg_r;

  always_comb begin
    seg_nxt = seg_r;
    case (cop)
      shac_pkg::COP_ROT: seg_nxt = from_next;
      shac_pkg::COP_WR: begin
        if (me == pos) seg_nxt = wdata;
      end
      shac_pkg::COP_INS: begin
        if (me == pos) seg_nxt = wdata;
        else if (me > pos) seg_nxt = from_prev;
      end
      shac_pkg::COP_DEL: begin
        if (me >= pos) seg_nxt = from_next;
      end
      shac_pkg::COP_DELW: begin
        if (me_p1 == pos && IDX + 1 < (1 << IW)) seg_nxt = wdata;
        else if (me >= pos) seg_nxt = from_next;
      end
      default: seg_nxt = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

endmodule

/* hw/rtl/shac_chain.sv */
// Ring of segment cells; cell 0 is the head seen by the sequencer.
module shac_chain #(
  parameter int N  = 32,
  parameter int IW = 5
) (
  input  logic                clk,
  input  shac_pkg::shac_cop_t cop,
  input  logic [IW-1:0]       pos,
  input  shac_pkg::shac_seg_t wdata,
  output shac_pkg::shac_seg_t head
);

  shac_pkg::shac_seg_t q [N];

  assign head = q[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    shac_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk       (clk),
      .cop       (cop),
      .pos       (pos),
      .wdata     (wdata),
      .from_next (q[(i + 1) % N]),
      .from_prev (q[(i + N - 1) % N]),
      .q         (q[i])
    );
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the segment heap allocator unit.
`timescale 1ns / 100ps

module tb_top;
  import shac_pkg::*;

  localparam int SEGS = 32;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  shac_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  shac_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  segment_heap_allocator_unit #(.MAX_SEGMENTS(SEGS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the heap tables
  logic [1:0] pol_shadow;
  int         heap_shadow;
  int         fr_start [SEGS];
  int         fr_len   [SEGS];
  int         fr_cnt;
  int         us_start [SEGS];
  int         us_len   [SEGS];
  int         us_cnt;
  int         bytes_free;

  shac_in_t   pending_reqs[$];
  shac_out_t  expected_results[$];
  int         live_blocks[$];
  int         errs;
  int         in_gap;
  int         out_gap;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void heap_load();
    int sz;
    sz = (heap_shadow > 65536) ? 65536 : heap_shadow;
    for (int i = 0; i < SEGS; i++) begin
      fr_start[i] = 0; fr_len[i] = 0; us_start[i] = 0; us_len[i] = 0;
    end
    us_cnt = 0;
    bytes_free = sz;
    fr_cnt = (sz == 0) ? 0 : 1;
    fr_len[0] = sz;
  endfunction

  function automatic shac_out_t model_alloc(int req);
    shac_out_t r;
    int need, pick, pos, g;
    bit found;
    r = '0;
    found = 0; pick = 0;
    if (req == 0) begin
      r.status = STAT_ZERO;
    end else begin
      need = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
      if (!(need > bytes_free || fr_cnt == 0)) begin
        for (int i = 0; i < fr_cnt; i++) begin
          if (fr_len[i] < need) continue;
          if (!found) begin
            found = 1; pick = i;
            if (pol_shadow != POL_BEST && pol_shadow != POL_WORST) break;
            continue;
          end
          if (pol_shadow == POL_BEST && fr_len[i] < fr_len[pick]) pick = i;
          if (pol_shadow == POL_WORST && fr_len[i] > fr_len[pick]) pick = i;
        end
      end
      if (!found) begin
        r.status = STAT_NOFIT;
      end else if (us_cnt >= SEGS) begin
        r.status = STAT_FULL;
      end else begin
        g = fr_start[pick];
        if (fr_len[pick] == need) begin
          for (int i = pick; i + 1 < fr_cnt; i++) begin
            fr_start[i] = fr_start[i+1]; fr_len[i] = fr_len[i+1];
          end
          fr_cnt--;
        end else begin
          fr_start[pick] += need;
          fr_len[pick] -= need;
        end
        pos = 0;
        while (pos < us_cnt && us_start[pos] < g) pos++;
        for (int i = us_cnt; i > pos; i--) begin
          us_start[i] = us_start[i-1]; us_len[i] = us_len[i-1];
        end
        us_start[pos] = g; us_len[pos] = need;
        us_cnt++;
        bytes_free -= need;
        r.status = STAT_OK;
        r.grant_addr = g[AW-1:0];
      end
    end
    r.free_bytes = bytes_free[LW-1:0];
    return r;
  endfunction

  function automatic shac_out_t model_free(int addr);
    shac_out_t r;
    int u, pos, len;
    bit mp, mn;
    r = '0;
    u = 0; pos = 0;
    while (u < us_cnt && us_start[u] != addr) u++;
    if (u >= us_cnt) begin
      r.status = STAT_NOTFOUND;
    end else begin
      len = us_len[u];
      while (pos < fr_cnt && fr_start[pos] < addr) pos++;
      mp = pos > 0 && fr_start[pos-1] + fr_len[pos-1] == addr;
      mn = pos < fr_cnt && addr + len == fr_start[pos];
      if (!mp && !mn && fr_cnt >= SEGS) begin
        r.status = STAT_FULL;
      end else begin
        for (int i = u; i + 1 < us_cnt; i++) begin
          us_start[i] = us_start[i+1]; us_len[i] = us_len[i+1];
        end
        us_cnt--;
        if (mp && mn) begin
          fr_len[pos-1] += len + fr_len[pos];
          for (int i = pos; i + 1 < fr_cnt; i++) begin
            fr_start[i] = fr_start[i+1]; fr_len[i] = fr_len[i+1];
          end
          fr_cnt--;
        end else if (mp) begin
          fr_len[pos-1] += len;
        end else if (mn) begin
          fr_start[pos] = addr;
          fr_len[pos] += len;
        end else begin
          for (int i = fr_cnt; i > pos; i--) begin
            fr_start[i] = fr_start[i-1]; fr_len[i] = fr_len[i-1];
          end
          fr_start[pos] = addr; fr_len[pos] = len;
          fr_cnt++;
        end
        bytes_free += len;
        r.status = STAT_OK;
      end
    end
    r.free_bytes = bytes_free[LW-1:0];
    return r;
  endfunction

  // Predict, record live grants, and queue the request
  task automatic post_req(logic op, int size, int addr);
    shac_in_t  q;
    shac_out_t r;
    q.op = op;
    q.req_size = size[LW-1:0];
    q.block_addr = addr[AW-1:0];
    if (op == OP_ALLOC) begin
      r = model_alloc(int'(q.req_size));
      if (r.status == STAT_OK) live_blocks.push_back(int'(r.grant_addr));
    end else begin
      r = model_free(int'(q.block_addr));
      if (r.status == STAT_OK) begin
        foreach (live_blocks[i]) begin
          if (live_blocks[i] == int'(q.block_addr)) begin
            live_blocks.delete(i);
            break;
          end
        end
      end
    end
    pending_reqs.push_back(q);
    expected_results.push_back(r);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_idle();
    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (2 * SEGS + 10) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, int val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_POLICY) begin
      pol_shadow = val[1:0];
    end else begin
      heap_shadow = val & 32'h1FFFF;
      live_blocks.delete();
      heap_load();
    end
  endtask

  task automatic run_phase(logic [1:0] pol, int heap, int n);
    int p, sz, k;
    wait_idle();
    reg_write(REG_POLICY, pol);
    reg_write(REG_HEAP, heap);
    for (int j = 0; j < n; j++) begin
      p = $urandom_range(0, 99);
      if (p < 52) begin
        k = $urandom_range(0, 99);
        if (k < 75) sz = $urandom_range(1, (heap < 64) ? heap : heap / 16);
        else if (k < 85) sz = $urandom_range(1, heap);
        else if (k < 95) sz = $urandom_range(0, 131071);
        else sz = 0;
        post_req(OP_ALLOC, sz, $urandom_range(0, 65535));
      end else if (p < 94 && live_blocks.size() > 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        post_req(OP_FREE, $urandom_range(0, 131071), live_blocks[k]);
      end else begin
        post_req(OP_FREE, $urandom_range(0, 131071), $urandom_range(0, 65535));
      end
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and result stall
  always @(posedge clk) begin
    shac_out_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_data);
          errs++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.status !== e.status)
            $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
          if (out_data.grant_addr !== e.grant_addr)
            $display("%0t: grant_addr exp %h got %h", $time, e.grant_addr,
                     out_data.grant_addr);
          if (out_data.free_bytes !== e.free_bytes)
            $display("%0t: free_bytes exp %0d got %0d", $time, e.free_bytes,
                     out_data.free_bytes);
          if (out_data !== e) errs++;
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= pick_gap();
      end
    end
  end

  initial begin
    errs = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pol_shadow = POL_FIRST;
    heap_shadow = 65536;
    heap_load();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero size, rounding, oversize, unknown frees, merges
    post_req(OP_ALLOC, 0, 0);
    post_req(OP_ALLOC, 1, 0);
    post_req(OP_ALLOC, 131071, 0);
    post_req(OP_ALLOC, 65537, 0);
    post_req(OP_ALLOC, 8, 0);
    post_req(OP_ALLOC, 17, 0);
    post_req(OP_ALLOC, 9, 0);
    post_req(OP_FREE, 0, 3);
    post_req(OP_FREE, 0, 65535);
    post_req(OP_FREE, 0, 8);
    post_req(OP_FREE, 0, 32);
    post_req(OP_FREE, 0, 16);
    post_req(OP_ALLOC, 24, 0);
    post_req(OP_FREE, 0, 0);
    post_req(OP_FREE, 0, 0);
    post_req(OP_ALLOC, 65504, 0);
    post_req(OP_ALLOC, 8, 0);
    post_req(OP_FREE, 0, 8);
    post_req(OP_FREE, 0, 0);
    post_req(OP_ALLOC, 65536, 0);

    run_phase(POL_FIRST, 65536, 300);
    run_phase(POL_BEST, 4096, 300);
    run_phase(POL_WORST, 65536, 300);
    run_phase(2'd3, 2048, 200);
    run_phase(POL_BEST, 8, 60);
    run_phase(POL_FIRST, 100, 100);
    run_phase(POL_WORST, 1000, 300);
    run_phase(POL_BEST, 131071, 60);

    wait_idle();
    if (errs == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/shac_pkg.sv
hw/rtl/shac_cell.sv
hw/rtl/shac_chain.sv
hw/rtl/segment_heap_allocator_unit.sv
tb/tb_top.sv
